// ----- rtl/genotype_field_parser_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Genotype field parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off in reset.
// ----------------------------------------------------------------------------
`ifndef GENOTYPE_FIELD_PARSER_UNIT_ASSERT_SVH
`define GENOTYPE_FIELD_PARSER_UNIT_ASSERT_SVH

// Check a property at every rising edge outside reset
`define GFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds
`define GFP_NEVER(lbl, cond, msg) \
  `GFP_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/gfp_pkg.sv -----
// ----------------------------------------------------------------------------
// gfp_pkg
// Types, character codes and token helpers for the genotype field parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

  // Default widths
  localparam int unsigned ALLELE_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF  = 8;

  // Result queue depth (two results per word at most)
  localparam int unsigned RES_DEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Token length codes (saturating)
  localparam logic [1:0] TOK_EMPTY = 2'd0;
  localparam logic [1:0] TOK_ONE   = 2'd1;
  localparam logic [1:0] TOK_MANY  = 2'd2;

  // Result kinds
  localparam logic KIND_ALLELE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Field status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_MIXED  = 2'd2
  } status_e;

  // Outcome of closing an allele token
  typedef struct packed {
    logic syntax;
    logic missing;
    logic called;
    logic emit;
  } tok_close_t;

  // Result queue write control; second is only set with first
  typedef struct packed {
    logic first;
    logic second;
  } res_push_t;

  // Classify a token at its separator
  function automatic tok_close_t close_token(logic [1:0] len, logic has_dot,
                                             logic lead_zero, logic syn_err);
    tok_close_t r;
    r = '0;
    if (len == TOK_EMPTY) begin
      r.syntax = 1'b1;
    end else if (len == TOK_ONE && has_dot) begin
      r.missing = 1'b1;
    end else if (len == TOK_MANY && (has_dot || lead_zero)) begin
      r.syntax = 1'b1;
    end else begin
      r.called = 1'b1;
      r.emit   = !syn_err;
    end
    return r;
  endfunction

endpackage

// ----- rtl/gfp_parser.sv -----
// ----------------------------------------------------------------------------
// gfp_parser
// Per-byte field state and result formation: up to two result words per accepted byte.
// ----------------------------------------------------------------------------
`include "genotype_field_parser_unit_assert.svh"

module gfp_parser import gfp_pkg::*; #(
  parameter int unsigned ALLELE_BITS = ALLELE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
  localparam int unsigned RES_W      = ALLELE_BITS + COUNT_BITS + 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             fire_i,
  input  logic [7:0]       char_i,
  input  logic             last_i,
  output res_push_t        push_o,
  output logic [RES_W-1:0] res0_o,
  output logic [RES_W-1:0] res1_o
);

  logic                   gt_present_q;
  logic                   in_gt_q, in_gt_d;
  logic                   nonempty_q, nonempty_d;
  logic                   syn_q, syn_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [1:0]             len_q, len_d;
  logic                   lz_q, lz_d;
  logic                   dot_q, dot_d;
  logic [ALLELE_BITS-1:0] acc_q, acc_d;
  logic                   slash_q, slash_d;
  logic                   bar_q, bar_d;
  logic                   miss_q, miss_d;
  logic                   called_q, called_d;

  tok_close_t             tc1, tc2;
  logic                   close1, gt_active;
  logic                   emit_a;
  logic [ALLELE_BITS-1:0] allele_v;
  logic [3:0]             digit;
  status_e                st;
  logic                   ph, am;
  logic [COUNT_BITS-1:0]  cnt_sum;
  logic [RES_W-1:0]       res_allele, res_sum;

  assign gt_active = in_gt_q && gt_present_q;
  // Digits '0' to '9' carry their value in the low nibble
  assign digit     = char_i[3:0];

  // Work out the next field state for this byte
  always_comb begin
    in_gt_d    = in_gt_q;
    nonempty_d = nonempty_q;
    syn_d      = syn_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    lz_d       = lz_q;
    dot_d      = dot_q;
    acc_d      = acc_q;
    slash_d    = slash_q;
    bar_d      = bar_q;
    miss_d     = miss_q;
    called_d   = called_q;
    tc1        = '0;
    tc2        = '0;
    close1     = 1'b0;
    emit_a     = 1'b0;
    allele_v   = '0;
    st         = ST_OK;
    ph         = 1'b0;
    am         = 1'b0;
    cnt_sum    = '0;

    // Byte itself
    if (char_i == CH_COLON) begin
      if (!nonempty_d) syn_d = 1'b1;
      if (cnt_d != '1) cnt_d = cnt_d + 1'b1;
      nonempty_d = 1'b0;
      close1     = gt_active;
      in_gt_d    = 1'b0;
    end else begin
      nonempty_d = 1'b1;
      if ((char_i >= CH_TAB && char_i <= CH_CR) || char_i == CH_SPACE) syn_d = 1'b1;
      if (gt_active) begin
        if (char_i == CH_SLASH || char_i == CH_BAR) begin
          close1 = 1'b1;
        end else if (char_i == CH_DOT) begin
          dot_d = 1'b1;
          if (len_d != TOK_MANY) len_d = len_d + 1'b1;
        end else if (char_i >= CH_ZERO && char_i <= CH_NINE) begin
          if (len_d == TOK_EMPTY) lz_d = (char_i == CH_ZERO);
          acc_d = (acc_d << 3) + (acc_d << 1)
                + {{(ALLELE_BITS-4){1'b0}}, digit};
          if (len_d != TOK_MANY) len_d = len_d + 1'b1;
        end else begin
          syn_d = 1'b1;
        end
      end
    end

    // Close the token at a separator or a colon
    if (close1) begin
      tc1      = close_token(len_d, dot_d, lz_d, syn_d);
      syn_d    = syn_d | tc1.syntax;
      miss_d   = miss_d | tc1.missing;
      called_d = called_d | tc1.called;
      if (tc1.emit) begin
        emit_a   = 1'b1;
        allele_v = acc_d;
      end
      len_d = TOK_EMPTY;
      lz_d  = 1'b0;
      dot_d = 1'b0;
      acc_d = '0;
      if (char_i == CH_SLASH) slash_d = 1'b1;
      if (char_i == CH_BAR)   bar_d   = 1'b1;
    end

    // End of field: close the last token and form the summary
    if (last_i) begin
      if (!nonempty_d) syn_d = 1'b1;
      if (cnt_d != '1) cnt_d = cnt_d + 1'b1;
      // Count reported in the summary, taken before the clear
      cnt_sum = cnt_d;
      if (in_gt_d && gt_present_q) begin
        tc2      = close_token(len_d, dot_d, lz_d, syn_d);
        syn_d    = syn_d | tc2.syntax;
        miss_d   = miss_d | tc2.missing;
        called_d = called_d | tc2.called;
        if (tc2.emit) begin
          emit_a   = 1'b1;
          allele_v = acc_d;
        end
      end
      if (syn_d) begin
        st = ST_SYNTAX;
      end else if (gt_present_q && ((slash_d && bar_d) || (miss_d && called_d))) begin
        st = ST_MIXED;
      end else begin
        st = ST_OK;
      end
      ph = (st == ST_OK) && gt_present_q && !slash_d;
      am = (st == ST_OK) && gt_present_q && miss_d && !called_d;

      // Return to the start-of-field state
      in_gt_d    = 1'b1;
      nonempty_d = 1'b0;
      syn_d      = 1'b0;
      cnt_d      = '0;
      len_d      = TOK_EMPTY;
      lz_d       = 1'b0;
      dot_d      = 1'b0;
      acc_d      = '0;
      slash_d    = 1'b0;
      bar_d      = 1'b0;
      miss_d     = 1'b0;
      called_d   = 1'b0;
    end
  end

  // Pack results: kind, allele, phased, all_missing, status, count, last
  assign res_allele = {KIND_ALLELE, allele_v, 1'b0, 1'b0, ST_OK,
                       {COUNT_BITS{1'b0}}, 1'b0};
  assign res_sum    = {KIND_SUMMARY, {ALLELE_BITS{1'b0}}, ph, am, st, cnt_sum, 1'b1};

  // Allele goes first when both results come from one byte
  assign push_o.first  = fire_i && (emit_a || last_i);
  assign push_o.second = fire_i && emit_a && last_i;
  assign res0_o        = emit_a ? res_allele : res_sum;
  assign res1_o        = res_sum;

  // Hold the genotype enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_present_q <= 1'b1;
    end else if (cfg_we_i) begin
      gt_present_q <= cfg_wdata_i;
    end
  end

  // Advance the field state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_gt_q    <= 1'b1;
      nonempty_q <= 1'b0;
      syn_q      <= 1'b0;
      cnt_q      <= '0;
      len_q      <= TOK_EMPTY;
      lz_q       <= 1'b0;
      dot_q      <= 1'b0;
      acc_q      <= '0;
      slash_q    <= 1'b0;
      bar_q      <= 1'b0;
      miss_q     <= 1'b0;
      called_q   <= 1'b0;
    end else if (fire_i) begin
      in_gt_q    <= in_gt_d;
      nonempty_q <= nonempty_d;
      syn_q      <= syn_d;
      cnt_q      <= cnt_d;
      len_q      <= len_d;
      lz_q       <= lz_d;
      dot_q      <= dot_d;
      acc_q      <= acc_d;
      slash_q    <= slash_d;
      bar_q      <= bar_d;
      miss_q     <= miss_d;
      called_q   <= called_d;
    end
  end

  `GFP_NEVER(a_allele_needs_gt, fire_i && emit_a && !gt_present_q, "allele with genotypes off")
  `GFP_NEVER(a_no_allele_after_err, fire_i && emit_a && syn_q, "allele after syntax error")
  `GFP_ASSERT(a_field_clears, fire_i && last_i |=> in_gt_q && !syn_q && cnt_q == '0, "field not cleared")

endmodule

// ----- rtl/gfp_res_queue.sv -----
// ----------------------------------------------------------------------------
// gfp_res_queue
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`include "genotype_field_parser_unit_assert.svh"

module gfp_res_queue import gfp_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  res_push_t        push_i,
  input  logic [WIDTH-1:0] data0_i,
  input  logic [WIDTH-1:0] data1_i,
  output logic             room2_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [RES_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_push;
  logic             do_pop;

  assign n_push  = CNT_W'(push_i.first) + CNT_W'(push_i.second);
  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign room2_o = cnt_q <= CNT_W'(RES_DEPTH - 2);
  assign data_o  = mem_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wptr_q + PTR_W'(n_push);
    rptr_d = rptr_q + PTR_W'(do_pop);
    cnt_d  = cnt_q + n_push - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Write up to two entries in order
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wptr_q] <= data0_i;
    end
    if (push_i.second) begin
      mem_q[wptr_q + 1'b1] <= data1_i;
    end
  end

  `GFP_NEVER(a_no_overflow, cnt_q + n_push > CNT_W'(RES_DEPTH), "result queue overflow")
  `GFP_NEVER(a_second_alone, push_i.second && !push_i.first, "second write without first")
  `GFP_ASSERT(a_pop_count, rst_ni && do_pop && n_push == '0 |=> cnt_q == $past(cnt_q) - 1'b1, "pop count mismatch")

endmodule

// ----- rtl/genotype_field_parser_unit.sv -----
// ----------------------------------------------------------------------------
// genotype_field_parser_unit
// Genotype field parser: bytes in, allele and summary results out.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle unless the input is stalled. Its state
// update is done in the cycle it is accepted and its results are visible in
// the next cycle from a four-entry result queue. A byte causes at most two
// results (an allele and, on the last byte, the field summary, in that
// order); the queue drains one result per cycle unless out_stall_i is high,
// so a field yielding more results than output cycles is paced by it. The
// input is stalled while fewer than two queue entries are free.
module genotype_field_parser_unit import gfp_pkg::*; #(
  parameter int unsigned ALLELE_BITS = ALLELE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             char_in_i,
  input  logic                   last_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   kind_o,
  output logic [ALLELE_BITS-1:0] allele_o,
  output logic                   phased_o,
  output logic                   all_missing_o,
  output logic [1:0]             status_o,
  output logic [COUNT_BITS-1:0]  value_count_o,
  output logic                   last_out_o
);

  localparam int unsigned RES_W = ALLELE_BITS + COUNT_BITS + 6;

  res_push_t        push;
  logic [RES_W-1:0] res0, res1, head;
  logic             room2, in_fire;

  assign in_stall_o = !room2;
  assign in_fire    = in_valid_i && room2;

  gfp_parser #(
    .ALLELE_BITS(ALLELE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (in_fire),
    .char_i     (char_in_i),
    .last_i     (last_in_i),
    .push_o     (push),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  gfp_res_queue #(
    .WIDTH(RES_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data0_i(res0),
    .data1_i(res1),
    .room2_o(room2),
    .valid_o(out_valid_o),
    .pop_i  (!out_stall_i),
    .data_o (head)
  );

  // Unpack the head result
  assign last_out_o    = head[0];
  assign value_count_o = head[COUNT_BITS:1];
  assign status_o      = head[COUNT_BITS+2:COUNT_BITS+1];
  assign all_missing_o = head[COUNT_BITS+3];
  assign phased_o      = head[COUNT_BITS+4];
  assign allele_o      = head[COUNT_BITS+4+ALLELE_BITS:COUNT_BITS+5];
  assign kind_o        = head[RES_W-1];

endmodule

// ----- sim/genotype_field_parser_checker.sv -----
// ----------------------------------------------------------------------------
// Genotype field parser checker
// Watches the byte and result channels of the parser, predicts the allele
// and summary results of every accepted word and compares them in order.
// ----------------------------------------------------------------------------
module genotype_field_parser_checker import gfp_pkg::*; #(
  parameter int unsigned ALLELE_BITS = ALLELE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [7:0]             char_i,
  input  logic                   last_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic                   kind_i,
  input  logic [ALLELE_BITS-1:0] allele_i,
  input  logic                   phased_i,
  input  logic                   all_missing_i,
  input  logic [1:0]             status_i,
  input  logic [COUNT_BITS-1:0]  value_count_i,
  input  logic                   last_out_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                   kind;
    logic [ALLELE_BITS-1:0] allele;
    logic                   phased;
    logic                   all_missing;
    logic [1:0]             status;
    logic [COUNT_BITS-1:0]  value_count;
    logic                   last_out;
  } field_result_t;

  // Expected allele and summary results, oldest first
  field_result_t parse_results_q[$];
  field_result_t want;

  // Mirror of the parser state and its register
  logic                   gt_enable;
  logic                   in_gt;
  logic                   val_nonempty;
  logic                   syn_err;
  logic [COUNT_BITS-1:0]  val_cnt;
  logic [1:0]             tok_len;
  logic                   tok_lz;
  logic                   tok_dot;
  logic [ALLELE_BITS-1:0] acc;
  logic                   saw_slash;
  logic                   saw_bar;
  logic                   saw_missing;
  logic                   saw_called;

  task automatic clear_token();
    tok_len = TOK_EMPTY;
    tok_lz  = 1'b0;
    tok_dot = 1'b0;
    acc     = '0;
  endtask

  task automatic clear_field();
    in_gt        = 1'b1;
    val_nonempty = 1'b0;
    syn_err      = 1'b0;
    val_cnt      = '0;
    clear_token();
    saw_slash    = 1'b0;
    saw_bar      = 1'b0;
    saw_missing  = 1'b0;
    saw_called   = 1'b0;
  endtask

  task automatic bump_value_count();
    if (val_cnt != '1) val_cnt = val_cnt + 1'b1;
  endtask

  // Classify the finished allele token; queue a called allele unless the
  // field already has a syntax error
  task automatic finish_allele_token();
    field_result_t r;
    if (tok_len == TOK_EMPTY) begin
      syn_err = 1'b1;
    end else if (tok_len == TOK_ONE && tok_dot) begin
      saw_missing = 1'b1;
    end else if (tok_len == TOK_MANY && (tok_dot || tok_lz)) begin
      syn_err = 1'b1;
    end else begin
      saw_called = 1'b1;
      if (!syn_err) begin
        r        = '0;
        r.kind   = KIND_ALLELE;
        r.allele = acc;
        parse_results_q.insert(parse_results_q.size(), r);
      end
    end
    clear_token();
  endtask

  // Advance the token state on one byte of the genotype subfield
  task automatic parse_genotype_byte(logic [7:0] c);
    if (c == CH_SLASH || c == CH_BAR) begin
      finish_allele_token();
      if (c == CH_SLASH) saw_slash = 1'b1;
      else saw_bar = 1'b1;
    end else if (c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE)) begin
      if (c == CH_DOT) begin
        tok_dot = 1'b1;
      end else begin
        if (tok_len == TOK_EMPTY) tok_lz = (c == CH_ZERO);
        acc = acc * 10 + (c - CH_ZERO);
      end
      if (tok_len != TOK_MANY) tok_len = tok_len + 1'b1;
    end else begin
      syn_err = 1'b1;
    end
  endtask

  // Predict all results of one accepted word
  task automatic predict_field_word(logic [7:0] c, logic lst);
    field_result_t r;
    status_e       st;
    if (c == CH_COLON) begin
      if (!val_nonempty) syn_err = 1'b1;
      bump_value_count();
      val_nonempty = 1'b0;
      if (in_gt) begin
        if (gt_enable) finish_allele_token();
        in_gt = 1'b0;
      end
    end else begin
      val_nonempty = 1'b1;
      if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) syn_err = 1'b1;
      if (in_gt && gt_enable) parse_genotype_byte(c);
    end

    // Close the field and queue its summary
    if (lst) begin
      if (!val_nonempty) syn_err = 1'b1;
      bump_value_count();
      if (in_gt && gt_enable) finish_allele_token();
      if (syn_err) st = ST_SYNTAX;
      else if (gt_enable && ((saw_slash && saw_bar) || (saw_missing && saw_called)))
        st = ST_MIXED;
      else st = ST_OK;
      r             = '0;
      r.kind        = KIND_SUMMARY;
      r.phased      = (st == ST_OK) && gt_enable && !saw_slash;
      r.all_missing = (st == ST_OK) && gt_enable && saw_missing && !saw_called;
      r.status      = st;
      r.value_count = val_cnt;
      r.last_out    = 1'b1;
      parse_results_q.insert(parse_results_q.size(), r);
      clear_field();
    end
  endtask

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Check results first, then predict from the word taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_results_q.delete();
      gt_enable    = 1'b1;
      clear_field();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (parse_results_q.size() == 0) begin
          $error("result with none expected: kind %0d allele %0d status %0d",
                 kind_i, allele_i, status_i);
          fail_count_o++;
        end else begin
          want = parse_results_q.pop_front();
          compare_field("kind", want.kind, kind_i);
          compare_field("allele", want.allele, allele_i);
          compare_field("phased", want.phased, phased_i);
          compare_field("all_missing", want.all_missing, all_missing_i);
          compare_field("status", want.status, status_i);
          compare_field("value_count", want.value_count, value_count_i);
          compare_field("last_out", want.last_out, last_out_i);
        end
      end
      if (in_valid_i && !in_stall_i) predict_field_word(char_i, last_i);
      if (cfg_we_i) gt_enable = cfg_wdata_i;
      pending_o = parse_results_q.size();
    end
  end

endmodule

// ----- sim/tb_genotype_field_parser_unit.sv -----
// ----------------------------------------------------------------------------
// Genotype field parser testbench
// Drives genotype field text into the parser with random idle gaps and
// output stalls, switches genotype parsing on and off between phases and
// leaves result checking to the checker.
// ----------------------------------------------------------------------------
module tb_genotype_field_parser_unit import gfp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_in_i;
  logic        last_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [31:0] allele_o;
  logic        phased_o;
  logic        all_missing_o;
  logic [1:0]  status_o;
  logic [7:0]  value_count_o;
  logic        last_out_o;

  int          fail_count;
  int          results_pending;
  int          words_sent;
  bit          in_steady;
  logic [7:0]  field_q[$];

  genotype_field_parser_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_in_i     (char_in_i),
    .last_in_i     (last_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .allele_o      (allele_o),
    .phased_o      (phased_o),
    .all_missing_o (all_missing_o),
    .status_o      (status_o),
    .value_count_o (value_count_o),
    .last_out_o    (last_out_o)
  );

  genotype_field_parser_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .char_i        (char_in_i),
    .last_i        (last_in_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_i        (kind_o),
    .allele_i      (allele_o),
    .phased_i      (phased_o),
    .all_missing_i (all_missing_o),
    .status_i      (status_o),
    .value_count_i (value_count_o),
    .last_out_i    (last_out_o),
    .fail_count_o  (fail_count),
    .pending_o     (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Output stall: random bursts, with stretches of no stall
  initial begin
    int  hold;
    bit  out_steady;
    hold        = 0;
    out_steady  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) out_steady = !out_steady;
      if (hold > 0) begin
        out_stall_i = 1'b1;
        hold--;
      end else begin
        out_stall_i = 1'b0;
        hold = out_steady ? 0 : pick_gap();
      end
    end
  end

  // Send one word, idling first for a random gap
  task automatic send_word(logic [7:0] c, logic lst);
    int gap;
    if ($urandom_range(0, 59) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    char_in_i  = c;
    last_in_i  = lst;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic send_field();
    foreach (field_q[i]) send_word(field_q[i], i == field_q.size() - 1);
    field_q.delete();
  endtask

  // Append one byte to the field being built
  task automatic add_byte(logic [7:0] c);
    field_q.insert(field_q.size(), c);
  endtask

  task automatic push_text(string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  task automatic send_text(string s);
    push_text(s);
    send_field();
  endtask

  // Push one decimal allele: small, full range, or long enough to wrap
  task automatic push_allele();
    int r;
    int nd;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      push_text($sformatf("%0d", $urandom_range(0, 9)));
    end else if (r < 75) begin
      push_text($sformatf("%0d", $urandom_range(10, 99)));
    end else if (r < 88) begin
      push_text($sformatf("%0d", $urandom()));
    end else if (r < 92) begin
      push_text("4294967295");
    end else begin
      nd = $urandom_range(9, 11);
      add_byte(CH_ZERO + 8'($urandom_range(1, 9)));
      repeat (nd) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  function automatic logic [7:0] pick_sep();
    return $urandom_range(0, 1) ? CH_SLASH : CH_BAR;
  endfunction

  // Push a non-genotype value of 1 to 4 bytes, rarely with whitespace
  task automatic push_value_text();
    logic [7:0] c;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 29) == 0) begin
        c = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
      end else begin
        c = 8'($urandom_range(33, 126));
        if (c == CH_COLON) c = "x";
      end
      add_byte(c);
    end
  endtask

  // Build one field: mostly well formed, some broken, some raw noise
  task automatic build_field();
    int         r;
    int         ntok;
    bit         mixed;
    bit         all_miss;
    logic [7:0] sep;
    string      specials;
    specials = "::/|..0123456789";
    r = $urandom_range(0, 99);
    if (r < 65) begin
      r = $urandom_range(0, 9);
      ntok     = (r == 0) ? 1 : (r < 8) ? 2 : $urandom_range(3, 4);
      mixed    = ($urandom_range(0, 11) == 0);
      all_miss = ($urandom_range(0, 6) == 0);
      sep      = pick_sep();
      for (int t = 0; t < ntok; t++) begin
        if (t > 0) add_byte(mixed ? pick_sep() : sep);
        if (all_miss || $urandom_range(0, 7) == 0) add_byte(CH_DOT);
        else push_allele();
      end
      repeat ($urandom_range(0, 3)) begin
        add_byte(CH_COLON);
        push_value_text();
      end
    end else if (r < 82) begin
      case ($urandom_range(0, 7))
        // empty first token
        0: begin
          add_byte(pick_sep());
          push_allele();
        end
        // leading zero on a long token
        1: begin
          add_byte(CH_ZERO);
          repeat ($urandom_range(1, 3)) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
          add_byte(pick_sep());
          push_allele();
        end
        // dot inside a long token
        2: begin
          if ($urandom_range(0, 1)) push_allele();
          else add_byte(CH_DOT);
          add_byte(CH_DOT);
          add_byte(pick_sep());
          push_allele();
        end
        // bad character in the genotype
        3: begin
          push_allele();
          add_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                        : 8'($urandom_range(65, 122)));
          push_allele();
        end
        // whitespace in the genotype
        4: begin
          push_allele();
          add_byte(pick_sep());
          add_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
          push_allele();
        end
        // trailing separator
        5: begin
          push_allele();
          add_byte(pick_sep());
        end
        // empty value after the genotype
        6: begin
          push_allele();
          add_byte(pick_sep());
          push_allele();
          add_byte(CH_COLON);
          if ($urandom_range(0, 1)) begin
            add_byte(CH_COLON);
            push_value_text();
          end
        end
        // empty genotype value
        default: begin
          add_byte(CH_COLON);
          push_value_text();
        end
      endcase
      if ($urandom_range(0, 1)) begin
        add_byte(CH_COLON);
        push_value_text();
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1)) add_byte(specials[$urandom_range(0, 15)]);
        else add_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic run_fields(int n_words);
    int stop;
    stop = words_sent + n_words;
    while (words_sent < stop) begin
      build_field();
      send_field();
    end
  endtask

  // Drop valid and hold until every expected result has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_genotypes_present(logic v);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    char_in_i   = '0;
    last_in_i   = 1'b0;
    words_sent  = 0;
    in_steady   = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed fields with genotypes enabled from reset
    send_text("0/1");
    send_text("./.");
    send_text(".|2");
    send_text("1/2|3");
    send_text("01");
    send_text("::");
    send_text(" ");
    add_byte(8'hFF);
    send_field();
    send_text("1/");
    send_text("9:a");

    // Random phases across both register settings
    write_genotypes_present(1'b0);
    run_fields(200);
    write_genotypes_present(1'b1);
    run_fields(300);
    // Saturate the value count
    push_text("3|4");
    repeat (260) push_text(":7");
    send_field();
    run_fields(250);
    write_genotypes_present(1'b0);
    run_fields(50);
    write_genotypes_present(1'b1);
    run_fields(100);

    wait_drained();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
